// ===== src/lrwb_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU write-back directory package
// Item types, control struct and fixed constants shared by the directory
// top level and its recency cells.
// ----------------------------------------------------------------------------
package lrwb_pkg;

  localparam int KeyFieldW  = 16;
  localparam int SlotFieldW = 4;
  localparam int CapW       = 5;
  localparam int MinCapacity = 3;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [KeyFieldW-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic                  hit;
    logic [SlotFieldW-1:0] slot;
    logic                  writeback;
    logic [KeyFieldW-1:0]  victim_key;
    logic                  fill;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clr_dirty;
  } cell_ctrl_t;

endpackage

// ===== src/lrwb_cell.sv =====
// ----------------------------------------------------------------------------
// Recency cell
// One position of the move-to-front chain: holds an entry's key, slot,
// valid and dirty marks, compares its key against the lookup key, and takes
// the entry of its left neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module lrwb_cell import lrwb_pkg::*; #(
  parameter int KEY_BITS = 16,
  parameter int SLOT_W   = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic                prev_valid_i,
  input  logic                prev_dirty_i,
  input  logic [KEY_BITS-1:0] prev_key_i,
  input  logic [SLOT_W-1:0]   prev_slot_i,
  input  logic [KEY_BITS-1:0] lookup_key_i,
  output logic                valid_o,
  output logic                dirty_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [SLOT_W-1:0]   slot_o,
  output logic                match_o
);

  logic                valid_q;
  logic                dirty_q;
  logic [KEY_BITS-1:0] key_q;
  logic [SLOT_W-1:0]   slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= prev_valid_i;
      dirty_q <= prev_dirty_i;
    end else if (ctrl_i.clr_dirty) begin
      dirty_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      key_q  <= prev_key_i;
      slot_q <= prev_slot_i;
    end
  end

  // An invalid cell never matches, so its unwritten key is never used.
  assign match_o = valid_q && (key_q == lookup_key_i);
  assign valid_o = valid_q;
  assign dirty_o = dirty_q;
  assign key_o   = key_q;
  assign slot_o  = slot_q;

endmodule

// ===== src/lru_writeback_cache_directory.sv =====
// ----------------------------------------------------------------------------
// LRU write-back cache directory
// Fully associative tag directory kept as a move-to-front chain of cells,
// with write-back of dirty victims and a flush walk over dirty entries.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A read or write access has two
// steps: ST_LOOK compares the key against every cell of the chain and picks
// the hit, fill or victim position, and ST_UPD shifts the chain so the entry
// lands in front, with the result loaded into the output register in the
// same cycle; ST_UPD waits while a stalled result still holds that register.
// The next item is accepted in the cycle after ST_UPD. A flush walks the
// chain from most to least recent, one cell a cycle except while a dirty
// cell's result waits behind a stalled one, and ends with a result marked
// last. Valid and dirty marks reset at once; no clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module lru_writeback_cache_directory import lrwb_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i
);

  localparam int SlotW    = $clog2(ENTRIES);
  localparam int OccW     = $clog2(ENTRIES + 1);
  localparam int KeyExtW  = (KEY_BITS > KeyFieldW) ? KEY_BITS : KeyFieldW;
  localparam int SlotExtW = (SlotW > SlotFieldW) ? SlotW : SlotFieldW;
  localparam int CmpW     = (OccW > CapW) ? OccW : CapW;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOOK  = 5'b00010,
    ST_UPD   = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_FEND  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CapW-1:0]     cap_q;
  logic [OccW-1:0]     occ_q, occ_d;
  logic [SlotW-1:0]    fl_idx_q, fl_idx_d;
  logic                out_valid_q;
  out_item_t           out_q, out_d;

  logic [1:0]          op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [SlotW-1:0]    pos_q;
  logic                hit_q;
  logic [SlotW-1:0]    new_slot_q;
  logic                new_dirty_q;
  logic                wb_q;
  logic [KEY_BITS-1:0] vkey_q;
  logic                grow_q;

  logic                in_accept;
  logic                out_free;
  logic                emit;
  logic                upd_go;
  logic                flush_clr;

  logic [ENTRIES-1:0]  c_valid, c_dirty, c_match;
  logic [KEY_BITS-1:0] c_key [ENTRIES];
  logic [SlotW-1:0]    c_slot [ENTRIES];
  logic [ENTRIES-1:0]  p_valid, p_dirty;
  logic [KEY_BITS-1:0] p_key [ENTRIES];
  logic [SlotW-1:0]    p_slot [ENTRIES];
  cell_ctrl_t          ctrl [ENTRIES];

  logic                hit;
  logic [SlotW-1:0]    hit_pos;
  logic [CmpW-1:0]     cap_ext, eff_cap;
  logic                can_grow;
  logic [OccW-1:0]     occ_m1;
  logic [SlotW-1:0]    rd_idx;
  logic                rd_valid, rd_dirty;
  logic [KEY_BITS-1:0] rd_key;
  logic [SlotW-1:0]    rd_slot;
  logic [KeyExtW-1:0]  key_in_ext, vkey_ext, rd_key_ext;
  logic [SlotExtW-1:0] new_slot_ext, rd_slot_ext;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The chain: cell 0 takes the entry being promoted, every other cell its
  // left neighbor.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (i == 0) begin
        p_valid[i] = 1'b1;
        p_dirty[i] = new_dirty_q;
        p_key[i]   = key_q;
        p_slot[i]  = new_slot_q;
      end else begin
        p_valid[i] = c_valid[i-1];
        p_dirty[i] = c_dirty[i-1];
        p_key[i]   = c_key[i-1];
        p_slot[i]  = c_slot[i-1];
      end
      ctrl[i].shift     = upd_go && (SlotW'(i) <= pos_q);
      ctrl[i].clr_dirty = flush_clr && (fl_idx_q == SlotW'(i));
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lrwb_cell #(
      .KEY_BITS (KEY_BITS),
      .SLOT_W   (SlotW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[g]),
      .prev_valid_i (p_valid[g]),
      .prev_dirty_i (p_dirty[g]),
      .prev_key_i   (p_key[g]),
      .prev_slot_i  (p_slot[g]),
      .lookup_key_i (key_q),
      .valid_o      (c_valid[g]),
      .dirty_o      (c_dirty[g]),
      .key_o        (c_key[g]),
      .slot_o       (c_slot[g]),
      .match_o      (c_match[g])
    );
  end

  // Keys are unique in the chain, so the match vector is one-hot or empty.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (c_match[i]) begin
        hit_pos = hit_pos | SlotW'(i);
      end
    end
  end
  assign hit = |c_match;

  always_comb begin
    cap_ext = CmpW'(cap_q);
    if (cap_q == '0 || cap_ext > CmpW'(ENTRIES)) begin
      eff_cap = CmpW'(ENTRIES);
    end else if (cap_ext < CmpW'(MinCapacity)) begin
      eff_cap = CmpW'(MinCapacity);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign can_grow = (CmpW'(occ_q) < eff_cap) || (occ_q == '0);
  assign occ_m1   = occ_q - OccW'(1);

  // Single read port into the chain: the flush pointer, the hit position
  // or the least recent valid cell.
  always_comb begin
    if (state_q == ST_FLUSH) begin
      rd_idx = fl_idx_q;
    end else if (hit) begin
      rd_idx = hit_pos;
    end else begin
      rd_idx = occ_m1[SlotW-1:0];
    end
  end
  assign rd_valid = c_valid[rd_idx];
  assign rd_dirty = c_dirty[rd_idx];
  assign rd_key   = c_key[rd_idx];
  assign rd_slot  = c_slot[rd_idx];

  assign key_in_ext   = KeyExtW'(in_item_i.key);
  assign vkey_ext     = KeyExtW'(vkey_q);
  assign rd_key_ext   = KeyExtW'(rd_key);
  assign new_slot_ext = SlotExtW'(new_slot_q);
  assign rd_slot_ext  = SlotExtW'(rd_slot);

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    fl_idx_d  = fl_idx_q;
    emit      = 1'b0;
    upd_go    = 1'b0;
    flush_clr = 1'b0;
    out_d     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (op_q == OP_READ || op_q == OP_WRITE) begin
          state_d = ST_UPD;
        end else if (op_q == OP_FLUSH) begin
          state_d  = ST_FLUSH;
          fl_idx_d = '0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          emit             = 1'b1;
          upd_go           = 1'b1;
          out_d.hit        = hit_q;
          out_d.slot       = new_slot_ext[SlotFieldW-1:0];
          out_d.writeback  = wb_q;
          out_d.victim_key = wb_q ? vkey_ext[KeyFieldW-1:0] : '0;
          out_d.fill       = !hit_q;
          out_d.last       = 1'b1;
          occ_d            = occ_q + OccW'(grow_q);
          state_d          = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!(rd_valid && rd_dirty) || out_free) begin
          if (rd_valid && rd_dirty) begin
            emit             = 1'b1;
            flush_clr        = 1'b1;
            out_d.slot       = rd_slot_ext[SlotFieldW-1:0];
            out_d.writeback  = 1'b1;
            out_d.victim_key = rd_key_ext[KeyFieldW-1:0];
          end
          if (fl_idx_q == SlotW'(ENTRIES - 1)) begin
            state_d = ST_FEND;
          end else begin
            fl_idx_d = fl_idx_q + SlotW'(1);
          end
        end
      end
      ST_FEND: begin
        if (out_free) begin
          emit       = 1'b1;
          out_d.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CapReset;
      occ_q       <= '0;
      fl_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      fl_idx_q <= fl_idx_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
    if (in_accept) begin
      op_q  <= in_item_i.opcode;
      key_q <= key_in_ext[KEY_BITS-1:0];
    end
    if (state_q == ST_LOOK) begin
      hit_q       <= hit;
      grow_q      <= !hit && can_grow;
      wb_q        <= !hit && !can_grow && rd_dirty;
      vkey_q      <= rd_key;
      new_dirty_q <= (hit && rd_dirty) || (op_q == OP_WRITE);
      if (hit) begin
        pos_q      <= hit_pos;
        new_slot_q <= rd_slot;
      end else if (can_grow) begin
        pos_q      <= occ_q[SlotW-1:0];
        new_slot_q <= occ_q[SlotW-1:0];
      end else begin
        pos_q      <= occ_m1[SlotW-1:0];
        new_slot_q <= rd_slot;
      end
    end
  end

  // Valid cells always form a prefix of the chain whose length is the
  // occupancy count.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(ENTRIES))
    else $error("occupancy above entry count");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(c_valid) == int'(occ_q))
    else $error("valid cells do not match occupancy");

  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(c_match))
    else $error("key present in more than one cell");

  a_upd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && out_free) |=> (out_valid_q && out_q.last))
    else $error("access update did not present its result");

endmodule

// ===== sim/lrwb_directory_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU write-back directory checker
// Watches the item, result and configuration ports of the directory, keeps
// its own copy of tags, dirty marks and recency order, and compares every
// result that leaves the block with the oldest predicted one.
// ----------------------------------------------------------------------------
module lrwb_directory_checker import lrwb_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  in_item_t        in_item_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  out_item_t       out_item_i,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  output int              fail_count_o,
  output int              pending_o
);

  logic [KeyFieldW-1:0] tag_q [ENTRIES];
  logic                 valid_q [ENTRIES];
  logic                 dirty_q [ENTRIES];
  int                   rank_q [ENTRIES];
  int                   occupancy_q;
  logic [CapW-1:0]      capacity_q = CapReset;
  out_item_t            expected_q [$];
  int                   mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  function automatic int eff_capacity();
    int c;
    c = capacity_q;
    if (c == 0 || c > ENTRIES) return ENTRIES;
    if (c < MinCapacity) return MinCapacity;
    return c;
  endfunction

  // Every valid entry more recent than the limit ages by one; slot s goes
  // to the front.
  function automatic void move_to_front(int s, int limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != s && valid_q[i] && rank_q[i] < limit) rank_q[i]++;
    end
    rank_q[s] = 0;
  endfunction

  function automatic void predict_access(logic is_write, logic [KeyFieldW-1:0] key);
    int        s;
    out_item_t res;
    s   = -1;
    res = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (s < 0 && valid_q[i] && tag_q[i] == key) s = i;
    end
    if (s >= 0) begin
      res.hit = 1'b1;
      move_to_front(s, rank_q[s]);
    end else if (occupancy_q < eff_capacity()) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (s < 0 && !valid_q[i]) s = i;
      end
      valid_q[s] = 1'b1;
      dirty_q[s] = 1'b0;
      tag_q[s]   = key;
      occupancy_q++;
      move_to_front(s, 256);
    end else begin
      // Once occupancy has reached the capacity, the least recent entry is
      // reused even if capacity was lowered below the current occupancy.
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (s < 0 || rank_q[i] >= rank_q[s])) s = i;
      end
      if (dirty_q[s]) begin
        res.writeback  = 1'b1;
        res.victim_key = tag_q[s];
      end
      dirty_q[s] = 1'b0;
      tag_q[s]   = key;
      move_to_front(s, 256);
    end
    if (is_write) dirty_q[s] = 1'b1;
    res.slot = SlotFieldW'(s);
    res.fill = !res.hit;
    res.last = 1'b1;
    expected_q.push_back(res);
  endfunction

  function automatic void predict_flush();
    out_item_t res;
    for (int r = 0; r < ENTRIES; r++) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && dirty_q[i] && rank_q[i] == r) begin
          res            = '0;
          res.slot       = SlotFieldW'(i);
          res.writeback  = 1'b1;
          res.victim_key = tag_q[i];
          expected_q.push_back(res);
          dirty_q[i] = 1'b0;
        end
      end
    end
    res      = '0;
    res.last = 1'b1;
    expected_q.push_back(res);
  endfunction

  function automatic void compare_field(string name, logic [KeyFieldW-1:0] exp_v,
                                        logic [KeyFieldW-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t exp;
    if (expected_q.size() == 0) begin
      $display("%0t: result with none expected, expected none, actual %h", $time, got);
      mismatch_count++;
      return;
    end
    exp = expected_q.pop_front();
    compare_field("hit", exp.hit, got.hit);
    compare_field("slot", exp.slot, got.slot);
    compare_field("writeback", exp.writeback, got.writeback);
    compare_field("victim_key", exp.victim_key, got.victim_key);
    compare_field("fill", exp.fill, got.fill);
    compare_field("last", exp.last, got.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_q[i]   = '0;
        valid_q[i] = 1'b0;
        dirty_q[i] = 1'b0;
        rank_q[i]  = 0;
      end
      occupancy_q = 0;
      capacity_q  = CapReset;
      expected_q.delete();
    end else begin
      if (cfg_we_i) capacity_q = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) begin
        case (in_item_i.opcode)
          OP_READ:  predict_access(1'b0, in_item_i.key);
          OP_WRITE: predict_access(1'b1, in_item_i.key);
          OP_FLUSH: predict_flush();
          default: ;
        endcase
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== sim/lru_writeback_cache_directory_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU write-back directory testbench
// Drives a directed burst and then random access and flush traffic through
// several capacity settings and back-pressure mixes; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module lru_writeback_cache_directory_tb import lrwb_pkg::*; ();

  localparam logic [1:0] OpUnused    = 2'd3;
  localparam int         SegItems    = 78;
  localparam int         SettleCycles = 40;
  localparam int         HoldCycles  = 300;
  localparam int         CycleLimit  = 400000;
  localparam int         DirCount    = 22;

  localparam logic [1:0] DirOp [DirCount] = '{
    OP_FLUSH, OP_READ, OP_WRITE, OP_WRITE, OP_READ, OpUnused, OP_READ, OP_READ,
    OP_READ, OP_WRITE, OP_FLUSH, OP_FLUSH, OP_WRITE, OP_WRITE, OP_READ, OpUnused,
    OP_WRITE, OP_READ, OP_FLUSH, OP_READ, OP_WRITE, OP_FLUSH
  };
  localparam logic [KeyFieldW-1:0] DirKey [DirCount] = '{
    16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 16'hAAAA, 16'h5555, 16'h0000,
    16'hFFFF, 16'h5555, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h5555,
    16'h0001, 16'hFFFE, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF
  };
  localparam logic [CapW-1:0] SegCaps [6] = '{5'd16, 5'd4, 5'd31, 5'd1, 5'd0, 5'd2};

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  in_item_t        in_item_i;
  logic            out_valid_o;
  logic            out_stall_i;
  out_item_t       out_item_o;
  logic            cfg_we_i;
  logic [CapW-1:0] cfg_wdata_i;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_armed;

  lru_writeback_cache_directory u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  lrwb_directory_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off that lets the block
  // back up into its input.
  initial begin : result_sink
    int  hold_left;
    bit  hold_used;
    hold_left   = 0;
    hold_used   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && !hold_used) begin
        hold_left = HoldCycles;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Entered at a falling edge; returns at the falling edge after the item
  // has been taken, with valid still high.
  task automatic send_item(input logic [1:0] op, input logic [KeyFieldW-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_item_i       <= '{opcode: op, key: key};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [KeyFieldW-1:0] key_pool [32];
    logic [1:0]           op;
    logic [KeyFieldW-1:0] key;
    logic [CapW-1:0]      cap;
    int                   win;
    int                   sent;
    int                   r;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    send_idle_pct = 16;
    recv_idle_pct = 58;
    hold_armed    = 1'b0;
    foreach (key_pool[i]) key_pool[i] = KeyFieldW'($urandom);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A capacity of three makes evictions and writebacks show up early.
    write_capacity(5'd3);
    for (int d = 0; d < DirCount; d++) send_item(DirOp[d], DirKey[d]);
    in_valid_i <= 1'b0;
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      cap = (seg == 1) ? CapW'($urandom_range(4, 15)) : SegCaps[seg];
      write_capacity(cap);
      send_idle_pct = (seg < 2) ? 16 : (seg < 4) ? 58 : 0;
      recv_idle_pct = (seg < 2) ? 58 : (seg < 4) ? 16 : 0;
      if (seg == 4) hold_armed = 1'b1;
      // Keep the key set a little larger than the capacity so that hits and
      // evictions both stay common.
      if (cap == 0 || cap > 16) win = 22;
      else if (cap < MinCapacity) win = MinCapacity + 6;
      else win = cap + 6;
      sent = 0;
      while (sent < SegItems) begin
        r = $urandom_range(99);
        if (r < 45) op = OP_READ;
        else if (r < 85) op = OP_WRITE;
        else if (r < 95) op = OP_FLUSH;
        else op = OpUnused;
        if ($urandom_range(9) == 0) key = KeyFieldW'($urandom);
        else key = key_pool[$urandom_range(win - 1)];
        send_item(op, key);
        if (op != OpUnused) sent++;
      end
      in_valid_i <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
